/* rtl/tdpt_pkg.sv */
package tdpt_pkg;

    localparam int SMALLEST_PRIME     = 2;
    localparam int SMALLEST_COMPOSITE = 4;
    localparam int FIRST_ODD_DIVISOR  = 3;
    localparam int FIRST_ODD_SQUARE   = 9;
    localparam int SQUARE_STEP_CONST  = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_BOUND,
        ST_DIV,
        ST_TEST,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic init_loop;
        logic div_start;
        logic div_step;
        logic next_div;
        logic emit;
        logic verdict;
    } t_cmd;

    typedef struct packed {
        logic lt_two;
        logic lt_four;
        logic even;
        logic bound_past;
        logic rem_zero;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

/* rtl/tdpt_ctrl.sv */
module tdpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tdpt_pkg::t_status i_status,
    output tdpt_pkg::t_cmd    o_cmd
);

    tdpt_pkg::t_state r_state;
    tdpt_pkg::t_state n_state;
    logic             r_verdict;
    logic             n_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tdpt_pkg::ST_IDLE;
            r_verdict <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_verdict <= n_verdict;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_verdict  = r_verdict;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.verdict = r_verdict;
        case (r_state)
            tdpt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tdpt_pkg::ST_CLASSIFY;
                end
            end
            tdpt_pkg::ST_CLASSIFY: begin
                if (i_status.lt_two) begin
                    n_verdict = 1'b0;
                    n_state   = tdpt_pkg::ST_EMIT;
                end else if (i_status.lt_four) begin
                    n_verdict = 1'b1;
                    n_state   = tdpt_pkg::ST_EMIT;
                end else if (i_status.even) begin
                    n_verdict = 1'b0;
                    n_state   = tdpt_pkg::ST_EMIT;
                end else begin
                    o_cmd.init_loop = 1'b1;
                    n_state         = tdpt_pkg::ST_BOUND;
                end
            end
            tdpt_pkg::ST_BOUND: begin
                if (i_status.bound_past) begin
                    n_verdict = 1'b1;
                    n_state   = tdpt_pkg::ST_EMIT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = tdpt_pkg::ST_TEST;
                end
            end
            tdpt_pkg::ST_TEST: begin
                if (i_status.rem_zero) begin
                    n_verdict = 1'b0;
                    n_state   = tdpt_pkg::ST_EMIT;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = tdpt_pkg::ST_BOUND;
                end
            end
            tdpt_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tdpt_datapath.sv */
module tdpt_datapath #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_candidate,
    input  tdpt_pkg::t_cmd         i_cmd,
    output tdpt_pkg::t_status      o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_is_prime,
    output logic [VALUE_WIDTH-1:0] o_prime_total,
    output logic [VALUE_WIDTH-1:0] o_largest_found
);

    localparam int SW = VALUE_WIDTH + 2;
    localparam int BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic [VALUE_WIDTH-1:0] r_n;
    logic [VALUE_WIDTH-1:0] r_d;
    logic [SW-1:0]          r_sq;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [BW-1:0]          r_bit;
    logic [VALUE_WIDTH-1:0] r_total;
    logic [VALUE_WIDTH-1:0] r_largest;
    logic                   r_prime;
    logic                   r_out_valid;

    logic [VALUE_WIDTH:0]   rem_sh;
    logic                   rem_ge;
    logic [VALUE_WIDTH:0]   rem_diff;
    logic                   out_free;

    assign rem_sh   = {r_rem, r_n[r_bit]};
    assign rem_ge   = rem_sh >= {1'b0, r_d};
    assign rem_diff = rem_sh - {1'b0, r_d};
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= i_candidate;
        end
        if (i_cmd.init_loop) begin
            r_d  <= VALUE_WIDTH'(tdpt_pkg::FIRST_ODD_DIVISOR);
            r_sq <= SW'(tdpt_pkg::FIRST_ODD_SQUARE);
        end else if (i_cmd.next_div) begin
            r_d  <= r_d + VALUE_WIDTH'(2);
            r_sq <= r_sq + ({2'b00, r_d} << 2) + SW'(tdpt_pkg::SQUARE_STEP_CONST);
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_bit <= BW'(VALUE_WIDTH - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
            r_bit <= r_bit - BW'(1);
        end
        if (i_cmd.emit) begin
            r_prime <= i_cmd.verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_largest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit && i_cmd.verdict) begin
                if (r_total != '1) begin
                    r_total <= r_total + VALUE_WIDTH'(1);
                end
                if (r_n > r_largest) begin
                    r_largest <= r_n;
                end
            end
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.lt_two     = r_n < VALUE_WIDTH'(tdpt_pkg::SMALLEST_PRIME);
        o_status.lt_four    = r_n < VALUE_WIDTH'(tdpt_pkg::SMALLEST_COMPOSITE);
        o_status.even       = !r_n[0];
        o_status.bound_past = r_sq > {2'b00, r_n};
        o_status.rem_zero   = r_rem == '0;
        o_status.div_last   = r_bit == '0;
        o_status.out_free   = out_free;
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_prime      = r_prime;
    assign o_prime_total   = r_total;
    assign o_largest_found = r_largest;

endmodule

/* rtl/trial_division_prime_tracker_top.sv */
// Candidates below 4 and even candidates are decided without trial division.
// Odd candidates are divided by the odd divisors 3, 5, 7 and on, until the k-th one divides n
// or, for a prime, the next one's square exceeds n after k odd divisors (k <= sqrt(n)/2);
// each remainder comes from a restoring divider that retires one bit per cycle.
// Only one candidate is in work at a time; the next beat is taken after the result is
// registered, later while a finished result stalls ahead of the output register.
// Reset (synchronous, active low): prime count and largest prime clear to zero, output empties.
module trial_division_prime_tracker_top #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // candidate
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // is_prime, prime_total, largest_found
    output logic [((2*VALUE_WIDTH+8)/8)*8-1:0]   m_axis_tdata
);

    localparam int OW = ((2 * VALUE_WIDTH + 8) / 8) * 8;
    localparam int PW = OW - (2 * VALUE_WIDTH + 1);

    tdpt_pkg::t_cmd         cmd;
    tdpt_pkg::t_status      status;
    logic                   is_prime;
    logic [VALUE_WIDTH-1:0] prime_total;
    logic [VALUE_WIDTH-1:0] largest_found;

    tdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tdpt_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_candidate     (s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_is_prime      (is_prime),
        .o_prime_total   (prime_total),
        .o_largest_found (largest_found)
    );

    generate
        if (PW > 0) begin : g_pad
            assign m_axis_tdata = {{PW{1'b0}}, largest_found, prime_total, is_prime};
        end else begin : g_nopad
            assign m_axis_tdata = {largest_found, prime_total, is_prime};
        end
    endgenerate

endmodule

/* rtl/tdpt_checker.sv */
module tdpt_checker #(
    parameter int VALUE_WIDTH = 31
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [((2*VALUE_WIDTH+8)/8)*8-1:0] m_axis_tdata
);

    logic                   out_prime;
    logic [VALUE_WIDTH-1:0] out_total;
    logic [VALUE_WIDTH-1:0] out_largest;

    assign out_prime   = m_axis_tdata[0];
    assign out_total   = m_axis_tdata[VALUE_WIDTH:1];
    assign out_largest = m_axis_tdata[2*VALUE_WIDTH:VALUE_WIDTH+1];

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(m_axis_tvalid) && !$past(m_axis_tready)
        |-> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> out_total >= $past(out_total))
        else $error("prime count went down");

    a_largest_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> out_largest >= $past(out_largest))
        else $error("largest prime went down");

    a_prime_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_prime |-> (out_total != '0) && (out_largest != '0))
        else $error("prime verdict without count or largest value");

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(s_axis_tvalid && s_axis_tready) |-> !s_axis_tready)
        else $error("input taken while a candidate is in work");

endmodule

bind trial_division_prime_tracker_top tdpt_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_tdpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/tb_trial_division_prime_tracker_top.sv */
`timescale 1ns / 100ps

module tb_trial_division_prime_tracker_top;

    localparam int VALUE_WIDTH  = 31;
    localparam int IN_W         = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_W        = ((2 * VALUE_WIDTH + 8) / 8) * 8;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int IDLE_PCT     = 28;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;

    class prime_scoreboard;
        typedef struct {
            bit                   prime;
            bit [VALUE_WIDTH-1:0] total;
            bit [VALUE_WIDTH-1:0] largest;
        } t_verdict;

        bit [VALUE_WIDTH-1:0] prime_count;
        bit [VALUE_WIDTH-1:0] largest_prime;
        t_verdict             pending_verdicts[$];
        int                   fail_count;
        int                   results_checked;

        function new();
            prime_count     = '0;
            largest_prime   = '0;
            fail_count      = 0;
            results_checked = 0;
        endfunction

        function bit test_prime(longint unsigned n);
            longint unsigned d;
            if (n < tdpt_pkg::SMALLEST_PRIME) return 1'b0;
            for (d = 2; d * d <= n; d++) begin
                if (n % d == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_candidate(bit [IN_W-1:0] word);
            bit [VALUE_WIDTH-1:0] n;
            t_verdict             v;
            n       = word[VALUE_WIDTH-1:0];
            v.prime = test_prime(n);
            if (v.prime) begin
                if (n > largest_prime) largest_prime = n;
                if (prime_count != '1) prime_count = prime_count + 1'b1;
            end
            v.total   = prime_count;
            v.largest = largest_prime;
            pending_verdicts.push_back(v);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            fail_count++;
        endtask

        task check_result(bit [OUT_W-1:0] word);
            t_verdict             v;
            bit                   got_prime;
            bit [VALUE_WIDTH-1:0] got_total;
            bit [VALUE_WIDTH-1:0] got_largest;
            got_prime   = word[0];
            got_total   = word[VALUE_WIDTH:1];
            got_largest = word[2*VALUE_WIDTH:VALUE_WIDTH+1];
            results_checked++;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("unexpected result beat %h", word));
            end else begin
                v = pending_verdicts.pop_front();
                if (got_prime != v.prime)
                    report($sformatf("result %0d is_prime %0d, want %0d",
                                     results_checked, got_prime, v.prime));
                if (got_total != v.total)
                    report($sformatf("result %0d prime_total %0d, want %0d",
                                     results_checked, got_total, v.total));
                if (got_largest != v.largest)
                    report($sformatf("result %0d largest_found %0d, want %0d",
                                     results_checked, got_largest, v.largest));
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    // candidate
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // is_prime, prime_total, largest_found
    logic [OUT_W-1:0]  m_axis_tdata;

    prime_scoreboard   sb = new();
    int                cycle_count = 0;
    bit                hold_done = 1'b0;

    trial_division_prime_tracker_top #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_trial_division_prime_tracker_top failed");
            $finish;
        end
    end

    task automatic send_candidate(bit [IN_W-1:0] word, bit allow_idle);
        if (allow_idle && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_candidate(word);
    endtask

    function automatic bit [IN_W-1:0] pick_candidate();
        int                   sel;
        int                   factor;
        bit [VALUE_WIDTH-1:0] n;
        bit                   pad;
        sel = $urandom_range(99);
        if (sel < 60) begin
            n = VALUE_WIDTH'($urandom_range(4095));
        end else if (sel < 75) begin
            n = VALUE_WIDTH'($urandom_range(65535, 4096));
        end else begin
            // keep wide values cheap: force a small factor
            case ($urandom_range(3))
                0:       factor = 2;
                1:       factor = 3;
                2:       factor = 5;
                default: factor = 7;
            endcase
            n = VALUE_WIDTH'($urandom);
            n = VALUE_WIDTH'(n - n % factor);
        end
        pad = ($urandom_range(9) == 0);
        return {pad, n};
    endfunction

    initial begin : sink
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (!hold_done && sb.results_checked >= 120) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (sb.results_checked >= 250 && sb.results_checked < 350) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : source
        bit [IN_W-1:0] directed_words[$];
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        directed_words = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
            32'd121, 32'd169, 32'd7, 32'd7, 32'd97, 32'd2, 32'd1021,
            32'd1048573, 32'd16777213, 32'd1021, 32'd2147483646, 32'd2147483645,
            32'h8000_0000, 32'h8000_000F, 32'h8000_0002, 32'h5555_5554
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_words[i]) send_candidate(directed_words[i], 1'b1);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_candidate(pick_candidate(), !(i >= 200 && i < 300));
        s_axis_tvalid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0)
            $display("tb_trial_division_prime_tracker_top passed");
        else
            $display("tb_trial_division_prime_tracker_top failed");
        $finish;
    end

endmodule
